/* rtl/sspg_pkg.sv */
// Shared types, constants and a helper function of the step/direction pulse generator.
package sspg_pkg;

	localparam int TICK_W     = 34;
	localparam int PERIOD_W   = 26;
	localparam int DIVSR_W    = 28;
	localparam int MUL_B_W    = 10;
	localparam int MUL_STEPS  = 10;
	localparam int MUL_CNT_W  = 4;
	localparam int DIV_STEPS  = 34;
	localparam int DIV_CNT_W  = 6;
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	localparam int SETUP_TICKS = 2;
	localparam int HIGH_TICKS  = 10;

	localparam logic [TICK_W-1:0]   PERIOD_NUM = TICK_W'(60000000);
	localparam logic [PERIOD_W-1:0] PERIOD_MAX = {PERIOD_W{1'b1}};
	localparam logic [DIVSR_W-1:0]  LOW_DIV    = DIVSR_W'(2000);
	localparam logic [MUL_B_W-1:0]  LOW_SCALE  = MUL_B_W'(1000);

	localparam logic [1:0] REQ_TICK    = 2'd0;
	localparam logic [1:0] REQ_MOVE    = 2'd1;
	localparam logic [1:0] REQ_RELEASE = 2'd2;
	localparam logic [1:0] REQ_ENABLE  = 2'd3;

	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_SETUP = 2'd1;
	localparam logic [1:0] PH_HIGH  = 2'd2;
	localparam logic [1:0] PH_LOW   = 2'd3;

	localparam logic [1:0] REG_STEPS_PER_REV = 2'd0;
	localparam logic [1:0] REG_SPEED_RPM     = 2'd1;
	localparam logic [1:0] REG_MICROSTEPS    = 2'd2;
	localparam logic [1:0] REG_INVERT_DIR    = 2'd3;

	localparam logic [12:0] RST_STEPS_PER_REV = 13'd200;
	localparam logic [9:0]  RST_SPEED_RPM     = 10'd60;
	localparam logic [4:0]  RST_MICROSTEPS    = 5'd1;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [15:0] step_count;
		logic        direction;
		logic [7:0]  delay_multiplier;
	} cmd_t;

	typedef struct packed {
		logic               step_pin;
		logic               dir_pin;
		logic               enable_n;
		logic [2:0]         microstep_select;
		logic               busy_res;
		logic               move_done;
		logic signed [31:0] position;
		logic               rejected;
	} res_t;

	typedef struct packed {
		logic [12:0] steps_per_rev;
		logic [9:0]  speed_rpm;
		logic [4:0]  microsteps;
		logic        invert_dir;
	} cfg_t;

	function automatic logic [2:0] msel_encode(input logic [4:0] ms);
		logic [2:0] pins;
		case (ms)
			5'd2:    pins = 3'b001;
			5'd4:    pins = 3'b010;
			5'd8:    pins = 3'b011;
			5'd16:   pins = 3'b111;
			default: pins = 3'b000;
		endcase
		return pins;
	endfunction

endpackage

/* rtl/stepper_step_dir_pulse_generator.sv */
// Top level of the step/direction pulse generator for a microstepping driver.
// Ticks, releases, re-enables and rejected commands are taken one per cycle while the result is not stalled
// and no move is being calculated, and each result transaction is registered and shows in the cycle after acceptance.
// A move runs four serial multiplies and two serial divides before its result is registered,
// and further commands are stalled meanwhile.
// Reset clears the pulse state, parks the position at zero and releases the driver.
module stepper_step_dir_pulse_generator (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cmd_valid,
	output logic                              cmd_stall,
	input  sspg_pkg::cmd_t                    cmd,
	output logic                              res_valid,
	input  logic                              res_stall,
	output sspg_pkg::res_t                    res,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [sspg_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [sspg_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [sspg_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready
);
	import sspg_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_CALC = 1'b1;

	cfg_t              cfg;
	logic              state_q;
	logic              res_valid_q;
	res_t              res_q;
	logic [1:0]        phase_q;
	logic [TICK_W-1:0] ticks_q;
	logic [15:0]       left_q;
	logic [31:0]       pos_q;
	logic              dirlvl_q;
	logic              dis_q;
	logic              fwd_q;
	logic [15:0]       count_q;
	logic              dir_q;

	logic              accept;
	logic              start_move;
	logic              calc_done;
	logic [TICK_W-1:0] low_ticks;

	logic [1:0]        phase_n;
	logic [TICK_W-1:0] ticks_n;
	logic [15:0]       left_n;
	logic [31:0]       pos_n;
	logic              dirlvl_n;
	logic              dis_n;
	logic              fwd_n;
	logic              do_end;
	logic              do_begin;
	logic              done_f;
	logic              rej_f;
	logic              load_res;
	res_t              res_n;

	sspg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sspg_period_calc u_calc (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start_move),
		.cfg       (cfg),
		.mult      (cmd.delay_multiplier),
		.done      (calc_done),
		.low_ticks (low_ticks)
	);

	assign cmd_stall  = (state_q == ST_CALC) || (res_valid_q && res_stall);
	assign accept     = cmd_valid && !cmd_stall;
	assign start_move = accept && cmd.req_type == REQ_MOVE && phase_q == PH_IDLE;
	assign load_res   = (accept && !start_move) || calc_done;

	always_comb begin
		phase_n  = phase_q;
		ticks_n  = ticks_q;
		left_n   = left_q;
		pos_n    = pos_q;
		dirlvl_n = dirlvl_q;
		dis_n    = dis_q;
		fwd_n    = fwd_q;
		do_end   = 1'b0;
		do_begin = 1'b0;
		done_f   = 1'b0;
		rej_f    = 1'b0;

		if (calc_done) begin
			left_n = count_q;
			fwd_n  = dir_q;
			if (count_q == '0) begin
				done_f = 1'b1;
			end else begin
				do_begin = 1'b1;
			end
		end else if (accept && !start_move) begin
			if (cmd.req_type == REQ_TICK) begin
				case (phase_q)
					PH_SETUP: begin
						if (ticks_q == TICK_W'(1)) begin
							phase_n = PH_HIGH;
							ticks_n = TICK_W'(HIGH_TICKS);
						end else begin
							ticks_n = ticks_q - 1'b1;
						end
					end
					PH_HIGH: begin
						if (ticks_q == TICK_W'(1)) begin
							phase_n = PH_LOW;
							ticks_n = low_ticks;
							if (low_ticks == '0) begin
								do_end = 1'b1;
							end
						end else begin
							ticks_n = ticks_q - 1'b1;
						end
					end
					PH_LOW: begin
						if (ticks_q <= TICK_W'(1)) begin
							ticks_n = '0;
							do_end  = 1'b1;
						end else begin
							ticks_n = ticks_q - 1'b1;
						end
					end
					default: ;
				endcase
			end else if (phase_q != PH_IDLE) begin
				rej_f = 1'b1;
			end else if (cmd.req_type == REQ_RELEASE) begin
				dis_n = 1'b1;
			end else begin
				dis_n = 1'b0;
			end
		end

		if (do_end) begin
			left_n = left_q - 1'b1;
			if (left_n == '0) begin
				phase_n = PH_IDLE;
				ticks_n = '0;
				done_f  = 1'b1;
			end else begin
				do_begin = 1'b1;
			end
		end

		if (do_begin) begin
			dis_n    = 1'b0;
			dirlvl_n = fwd_n ? cfg.invert_dir : !cfg.invert_dir;
			pos_n    = fwd_n ? pos_q + 32'd1 : pos_q - 32'd1;
			phase_n  = PH_SETUP;
			ticks_n  = TICK_W'(SETUP_TICKS);
		end

		res_n.step_pin         = phase_n == PH_HIGH;
		res_n.dir_pin          = dirlvl_n;
		res_n.enable_n         = dis_n;
		res_n.microstep_select = msel_encode(cfg.microsteps);
		res_n.busy_res         = phase_n != PH_IDLE;
		res_n.move_done        = done_f;
		res_n.position         = pos_n;
		res_n.rejected         = rej_f;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
			phase_q     <= PH_IDLE;
			ticks_q     <= '0;
			left_q      <= '0;
			pos_q       <= '0;
			dirlvl_q    <= 1'b0;
			dis_q       <= 1'b1;
			fwd_q       <= 1'b1;
		end else begin
			if (start_move) begin
				state_q <= ST_CALC;
			end else if (calc_done) begin
				state_q <= ST_IDLE;
			end
			if (load_res) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			phase_q  <= phase_n;
			ticks_q  <= ticks_n;
			left_q   <= left_n;
			pos_q    <= pos_n;
			dirlvl_q <= dirlvl_n;
			dis_q    <= dis_n;
			fwd_q    <= fwd_n;
		end
	end

	always_ff @(posedge clk) begin
		if (start_move) begin
			count_q <= cmd.step_count;
			dir_q   <= cmd.direction;
		end
		if (load_res) begin
			res_q <= res_n;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

/* rtl/sspg_serial_mul.sv */
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
module sspg_serial_mul (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [sspg_pkg::TICK_W-1:0]       a,
	input  logic [sspg_pkg::MUL_B_W-1:0]      b,
	output logic                              done,
	output logic [sspg_pkg::TICK_W-1:0]       product
);
	import sspg_pkg::*;

	logic [TICK_W-1:0]    a_q;
	logic [MUL_B_W-1:0]   b_q;
	logic [TICK_W-1:0]    acc_q;
	logic [MUL_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= MUL_CNT_W'(MUL_STEPS);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == MUL_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= {a_q[TICK_W-2:0], 1'b0};
			b_q <= {1'b0, b_q[MUL_B_W-1:1]};
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

/* rtl/sspg_serial_div.sv */
// Restoring radix-2 divider, one quotient bit per cycle.
module sspg_serial_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [sspg_pkg::TICK_W-1:0]       dividend,
	input  logic [sspg_pkg::DIVSR_W-1:0]      divisor,
	output logic                              done,
	output logic [sspg_pkg::TICK_W-1:0]       quotient
);
	import sspg_pkg::*;

	logic [TICK_W-1:0]    dq_q;
	logic [DIVSR_W-1:0]   rem_q;
	logic [DIVSR_W-1:0]   dsr_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIVSR_W:0]     trial;
	logic [DIVSR_W:0]     diff;
	logic                 ge;

	assign trial = {rem_q, dq_q[TICK_W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign ge    = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= DIV_CNT_W'(DIV_STEPS);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIVSR_W-1:0] : trial[DIVSR_W-1:0];
			dq_q  <= {dq_q[TICK_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = dq_q;

endmodule

/* rtl/sspg_period_calc.sv */
// Sequencer that derives the step period and the low time of a move with serial units.
module sspg_period_calc (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  sspg_pkg::cfg_t               cfg,
	input  logic [7:0]                   mult,
	output logic                         done,
	output logic [sspg_pkg::TICK_W-1:0]  low_ticks
);
	import sspg_pkg::*;

	localparam logic [2:0] C_IDLE = 3'd0;
	localparam logic [2:0] C_MUL1 = 3'd1;
	localparam logic [2:0] C_MUL2 = 3'd2;
	localparam logic [2:0] C_DIV1 = 3'd3;
	localparam logic [2:0] C_MUL3 = 3'd4;
	localparam logic [2:0] C_DIV2 = 3'd5;
	localparam logic [2:0] C_MUL4 = 3'd6;

	logic [2:0]          state_q;
	logic                go_q;
	logic                done_q;
	logic [7:0]          mult_q;
	logic [TICK_W-1:0]   tmp_q;
	logic [PERIOD_W-1:0] period_q;
	logic [TICK_W-1:0]   prod_q;
	logic [TICK_W-1:0]   low_q;

	logic [TICK_W-1:0]  mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [TICK_W-1:0]  div_dd;
	logic [DIVSR_W-1:0] div_ds;
	logic               mul_start;
	logic               div_start;
	logic               mul_done;
	logic               div_done;
	logic [TICK_W-1:0]  mul_p;
	logic [TICK_W-1:0]  div_q;

	always_comb begin
		mul_a     = tmp_q;
		mul_b     = LOW_SCALE;
		div_dd    = prod_q;
		div_ds    = LOW_DIV;
		mul_start = 1'b0;
		div_start = 1'b0;
		case (state_q)
			C_MUL1: begin
				mul_a     = TICK_W'(cfg.steps_per_rev);
				mul_b     = cfg.speed_rpm;
				mul_start = go_q;
			end
			C_MUL2: begin
				mul_b     = MUL_B_W'(cfg.microsteps);
				mul_start = go_q;
			end
			C_DIV1: begin
				div_dd    = PERIOD_NUM;
				div_ds    = tmp_q[DIVSR_W-1:0];
				div_start = go_q;
			end
			C_MUL3: begin
				mul_a     = TICK_W'(period_q);
				mul_b     = MUL_B_W'(mult_q);
				mul_start = go_q;
			end
			C_DIV2: begin
				div_start = go_q;
			end
			C_MUL4: begin
				mul_start = go_q;
			end
			default: ;
		endcase
	end

	sspg_serial_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (mul_a),
		.b       (mul_b),
		.done    (mul_done),
		.product (mul_p)
	);

	sspg_serial_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dd),
		.divisor  (div_ds),
		.done     (div_done),
		.quotient (div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			go_q    <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			go_q   <= 1'b0;
			done_q <= 1'b0;
			case (state_q)
				C_IDLE: begin
					if (start) begin
						state_q <= C_MUL1;
						go_q    <= 1'b1;
					end
				end
				C_MUL1: begin
					if (mul_done) begin
						state_q <= C_MUL2;
						go_q    <= 1'b1;
					end
				end
				C_MUL2: begin
					if (mul_done) begin
						state_q <= C_DIV1;
						go_q    <= 1'b1;
					end
				end
				C_DIV1: begin
					if (div_done) begin
						state_q <= C_MUL3;
						go_q    <= 1'b1;
					end
				end
				C_MUL3: begin
					if (mul_done) begin
						state_q <= C_DIV2;
						go_q    <= 1'b1;
					end
				end
				C_DIV2: begin
					if (div_done) begin
						state_q <= C_MUL4;
						go_q    <= 1'b1;
					end
				end
				C_MUL4: begin
					if (mul_done) begin
						state_q <= C_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= C_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == C_IDLE && start) begin
			mult_q <= mult;
		end
		if ((state_q == C_MUL1 || state_q == C_MUL2) && mul_done) begin
			tmp_q <= mul_p;
		end
		if (state_q == C_DIV1 && div_done) begin
			if (tmp_q == '0) begin
				period_q <= PERIOD_MAX;
			end else begin
				period_q <= div_q[PERIOD_W-1:0];
			end
		end
		if (state_q == C_MUL3 && mul_done) begin
			prod_q <= mul_p;
		end
		if (state_q == C_DIV2 && div_done) begin
			tmp_q <= div_q;
		end
		if (state_q == C_MUL4 && mul_done) begin
			low_q <= mul_p + {1'b0, prod_q[TICK_W-1:1]};
		end
	end

	assign done      = done_q;
	assign low_ticks = low_q;

endmodule

/* rtl/sspg_regs.sv */
// APB configuration registers of the pulse generator.
module sspg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [sspg_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [sspg_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [sspg_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready,
	output sspg_pkg::cfg_t                    cfg
);
	import sspg_pkg::*;

	cfg_t       cfg_q;
	logic [1:0] idx;
	logic       wr_en;

	assign idx    = paddr[APB_ADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.steps_per_rev <= RST_STEPS_PER_REV;
			cfg_q.speed_rpm     <= RST_SPEED_RPM;
			cfg_q.microsteps    <= RST_MICROSTEPS;
			cfg_q.invert_dir    <= 1'b0;
		end else if (wr_en) begin
			case (idx)
				REG_STEPS_PER_REV: cfg_q.steps_per_rev <= pwdata[12:0];
				REG_SPEED_RPM:     cfg_q.speed_rpm     <= pwdata[9:0];
				REG_MICROSTEPS:    cfg_q.microsteps    <= pwdata[4:0];
				REG_INVERT_DIR:    cfg_q.invert_dir    <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_STEPS_PER_REV: prdata = APB_DATA_W'(cfg_q.steps_per_rev);
			REG_SPEED_RPM:     prdata = APB_DATA_W'(cfg_q.speed_rpm);
			REG_MICROSTEPS:    prdata = APB_DATA_W'(cfg_q.microsteps);
			REG_INVERT_DIR:    prdata = APB_DATA_W'(cfg_q.invert_dir);
			default:           prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

/* tb/stepper_step_dir_pulse_generator_checker.sv */
// Checker that predicts and compares the pulse generator's result transactions and register reads.
`timescale 1ns / 100ps
module stepper_step_dir_pulse_generator_checker
	import sspg_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	input  logic                  cmd_stall,
	input  cmd_t                  cmd,
	input  logic                  res_valid,
	input  logic                  res_stall,
	input  res_t                  res,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	input  logic [APB_DATA_W-1:0] prdata,
	input  logic                  pready,
	output int                    fails,
	output int                    pending,
	output int                    moves_done,
	output int                    rejects
);

	localparam logic [33:0] PERIOD_DIVIDEND = 34'd60000000;
	localparam logic [33:0] LOW_BLOCK       = 34'd2000;
	localparam logic [33:0] LOW_BLOCK_TICKS = 34'd1000;

	cfg_t        cfg;
	logic [1:0]  stage;
	logic [25:0] period_us;
	logic [33:0] low_len;
	logic [33:0] ticks_left;
	logic [15:0] steps_left;
	logic [31:0] position;
	logic        dir_level;
	logic        released;
	logic        fwd;
	res_t        pin_states[$];

	function automatic logic [2:0] select_pins(input logic [4:0] ms);
		logic [2:0] pins;
		case (ms)
			5'd2:    pins = 3'b001;
			5'd4:    pins = 3'b010;
			5'd8:    pins = 3'b011;
			5'd16:   pins = 3'b111;
			default: pins = 3'b000;
		endcase
		return pins;
	endfunction

	function automatic void start_pulse();
		released = 1'b0;
		if (fwd) begin
			dir_level = cfg.invert_dir;
			position = position + 32'd1;
		end else begin
			dir_level = ~cfg.invert_dir;
			position = position - 32'd1;
		end
		stage = PH_SETUP;
		ticks_left = 34'(SETUP_TICKS);
	endfunction

	function automatic logic close_pulse();
		steps_left = steps_left - 16'd1;
		if (steps_left == 16'd0) begin
			stage = PH_IDLE;
			ticks_left = '0;
			return 1'b1;
		end
		start_pulse();
		return 1'b0;
	endfunction

	task automatic clear_state();
		cfg.steps_per_rev = RST_STEPS_PER_REV;
		cfg.speed_rpm = RST_SPEED_RPM;
		cfg.microsteps = RST_MICROSTEPS;
		cfg.invert_dir = 1'b0;
		stage = PH_IDLE;
		period_us = '0;
		low_len = '0;
		ticks_left = '0;
		steps_left = '0;
		position = '0;
		dir_level = 1'b0;
		released = 1'b1;
		fwd = 1'b1;
	endtask

	task automatic advance_pulse(input cmd_t c, output res_t r);
		logic [27:0] divisor;
		logic [33:0] quotient;
		logic [33:0] product;
		logic        done;
		logic        rej;
		done = 1'b0;
		rej = 1'b0;
		if (c.req_type == REQ_TICK) begin
			case (stage)
				PH_SETUP: begin
					ticks_left = ticks_left - 34'd1;
					if (ticks_left == '0) begin
						stage = PH_HIGH;
						ticks_left = 34'(HIGH_TICKS);
					end
				end
				PH_HIGH: begin
					ticks_left = ticks_left - 34'd1;
					if (ticks_left == '0) begin
						stage = PH_LOW;
						ticks_left = low_len;
						if (ticks_left == '0)
							done = close_pulse();
					end
				end
				PH_LOW: begin
					if (ticks_left != '0)
						ticks_left = ticks_left - 34'd1;
					if (ticks_left == '0)
						done = close_pulse();
				end
				default: ;
			endcase
		end else if (stage != PH_IDLE) begin
			rej = 1'b1;
		end else if (c.req_type == REQ_MOVE) begin
			divisor = 28'(cfg.steps_per_rev) * 28'(cfg.speed_rpm) * 28'(cfg.microsteps);
			if (divisor == '0) begin
				period_us = PERIOD_MAX;
			end else begin
				quotient = PERIOD_DIVIDEND / 34'(divisor);
				period_us = (quotient > 34'(PERIOD_MAX)) ? PERIOD_MAX : quotient[25:0];
			end
			product = 34'(c.delay_multiplier) * 34'(period_us);
			low_len = LOW_BLOCK_TICKS * (product / LOW_BLOCK) + (product >> 1);
			steps_left = c.step_count;
			fwd = c.direction;
			if (c.step_count == 16'd0)
				done = 1'b1;
			else
				start_pulse();
		end else if (c.req_type == REQ_RELEASE) begin
			released = 1'b1;
		end else begin
			released = 1'b0;
		end
		r.step_pin = (stage == PH_HIGH);
		r.dir_pin = dir_level;
		r.enable_n = released;
		r.microstep_select = select_pins(cfg.microsteps);
		r.busy_res = (stage != PH_IDLE);
		r.move_done = done;
		r.position = position;
		r.rejected = rej;
	endtask

	task automatic match_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fails++;
		end
	endtask

	task automatic compare_pins(input res_t want, input res_t got);
		match_field("step_pin", 32'(want.step_pin), 32'(got.step_pin));
		match_field("dir_pin", 32'(want.dir_pin), 32'(got.dir_pin));
		match_field("enable_n", 32'(want.enable_n), 32'(got.enable_n));
		match_field("microstep_select", 32'(want.microstep_select), 32'(got.microstep_select));
		match_field("busy_res", 32'(want.busy_res), 32'(got.busy_res));
		match_field("move_done", 32'(want.move_done), 32'(got.move_done));
		match_field("position", want.position, got.position);
		match_field("rejected", 32'(want.rejected), 32'(got.rejected));
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		res_t want;
		if (!arst_n) begin
			clear_state();
			pin_states.delete();
			fails = 0;
			pending = 0;
			moves_done = 0;
			rejects = 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (pin_states.size() == 0) begin
					$error("result transaction with no expectation waiting");
					fails++;
				end else begin
					want = pin_states.pop_front();
					compare_pins(want, res);
				end
			end
			if (psel && penable && pready) begin
				if (pwrite) begin
					case (paddr[3:2])
						REG_STEPS_PER_REV: cfg.steps_per_rev = pwdata[12:0];
						REG_SPEED_RPM:     cfg.speed_rpm = pwdata[9:0];
						REG_MICROSTEPS:    cfg.microsteps = pwdata[4:0];
						REG_INVERT_DIR:    cfg.invert_dir = pwdata[0];
						default: ;
					endcase
				end else begin
					case (paddr[3:2])
						REG_STEPS_PER_REV: match_field("prdata steps_per_rev",
							32'(cfg.steps_per_rev), 32'(prdata[12:0]));
						REG_SPEED_RPM:     match_field("prdata speed_rpm",
							32'(cfg.speed_rpm), 32'(prdata[9:0]));
						REG_MICROSTEPS:    match_field("prdata microsteps",
							32'(cfg.microsteps), 32'(prdata[4:0]));
						REG_INVERT_DIR:    match_field("prdata invert_dir",
							32'(cfg.invert_dir), 32'(prdata[0]));
						default: ;
					endcase
				end
			end
			if (cmd_valid && !cmd_stall) begin
				advance_pulse(cmd, want);
				pin_states.push_back(want);
				if (want.move_done)
					moves_done++;
				if (want.rejected)
					rejects++;
			end
			pending = pin_states.size();
		end
	end

endmodule

/* tb/stepper_step_dir_pulse_generator_tb.sv */
// Testbench top: clock, reset, command and register stimulus, receiver stalls and the verdict.
`timescale 1ns / 100ps
module stepper_step_dir_pulse_generator_tb;
	import sspg_pkg::*;

	localparam int CYCLE_LIMIT       = 1000000;
	localparam int TAIL_CYCLES       = 200;
	localparam int HOLD_CYCLES       = 400;
	localparam int FLUSH_GUARD       = 20000;
	localparam int ITEMS_PER_SETTING = 120;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cmd_valid = 1'b0;
	logic                  cmd_stall;
	cmd_t                  cmd = '0;
	logic                  res_valid;
	logic                  res_stall = 1'b0;
	res_t                  res;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	int                    fails;
	int                    pending;
	int                    moves_done;
	int                    rejects;

	int cycles = 0;
	int sent = 0;
	int settings = 0;
	int gap_pct = 0;
	int stall_pct = 0;
	bit calm = 1'b0;
	bit hold_req = 1'b0;
	bit last_busy = 1'b0;

	stepper_step_dir_pulse_generator i_dut (.*);
	stepper_step_dir_pulse_generator_checker i_checker (.*);

	always #2 clk = ~clk;

	always @(posedge clk)
		if (res_valid && !res_stall)
			last_busy <= res.busy_res;

	initial begin
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				res_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
				res_stall <= 1'b1;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end else begin
				res_stall <= 1'b0;
				@(posedge clk);
			end
		end
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Timeout after %0d cycles with %0d results outstanding.", cycles, pending);
		$display("Simulation FAILED");
		$finish;
	end

	task automatic send_cmd(input logic [1:0] req, input logic [15:0] count, input logic dir,
			input logic [7:0] mult);
		cmd_t c;
		c.req_type = req;
		c.step_count = count;
		c.direction = dir;
		c.delay_multiplier = mult;
		if (!calm && $urandom_range(0, 99) < gap_pct) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		cmd <= c;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		sent++;
	endtask

	task automatic random_tick();
		send_cmd(REQ_TICK, 16'($urandom), 1'($urandom), 8'($urandom));
	endtask

	task automatic drain();
		cmd_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
		@(posedge clk);
	endtask

	task automatic apb_transfer(input logic [1:0] idx, input logic wr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= APB_ADDR_W'({idx, 2'b00});
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
	endtask

	task automatic read_back();
		apb_transfer(REG_STEPS_PER_REV, 1'b0, '0);
		apb_transfer(REG_SPEED_RPM, 1'b0, '0);
		apb_transfer(REG_MICROSTEPS, 1'b0, '0);
		apb_transfer(REG_INVERT_DIR, 1'b0, '0);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic load_setting(input logic [12:0] spr, input logic [9:0] rpm, input logic [4:0] ms,
			input logic inv);
		apb_transfer(REG_STEPS_PER_REV, 1'b1, 32'(spr));
		apb_transfer(REG_SPEED_RPM, 1'b1, 32'(rpm));
		apb_transfer(REG_MICROSTEPS, 1'b1, 32'(ms));
		apb_transfer(REG_INVERT_DIR, 1'b1, 32'(inv));
		read_back();
		settings++;
	endtask

	task automatic settle_move();
		int n;
		n = 0;
		drain();
		while (last_busy && n < FLUSH_GUARD) begin
			random_tick();
			n++;
		end
		drain();
	endtask

	task automatic run_setting(input logic [12:0] spr, input logic [9:0] rpm, input logic [4:0] ms,
			input logic inv, input int mult_cap, input int cnt_cap, input int gaps,
			input int stalls, input int hold_at, input bit settle);
		int          r;
		logic [1:0]  req;
		logic [15:0] count;
		logic [7:0]  mult;
		load_setting(spr, rpm, ms, inv);
		gap_pct = gaps;
		stall_pct = stalls;
		for (int i = 0; i < ITEMS_PER_SETTING; i++) begin
			if (i == hold_at)
				hold_req = 1'b1;
			r = $urandom_range(0, 99);
			count = 16'($urandom);
			mult = 8'($urandom);
			if (r < 62) begin
				req = REQ_TICK;
			end else if (r < 82) begin
				req = REQ_MOVE;
				count = 16'($urandom_range(0, cnt_cap));
				mult = 8'($urandom_range(0, mult_cap));
			end else if (r < 91) begin
				req = REQ_RELEASE;
			end else begin
				req = REQ_ENABLE;
			end
			send_cmd(req, count, 1'($urandom), mult);
		end
		if (settle)
			settle_move();
		else
			drain();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		read_back();

		gap_pct = 20;
		stall_pct = 20;
		send_cmd(REQ_TICK, 16'hFFFF, 1'b1, 8'hFF);
		send_cmd(REQ_RELEASE, 16'h0000, 1'b0, 8'h00);
		send_cmd(REQ_ENABLE, 16'h5A5A, 1'b1, 8'hA5);
		send_cmd(REQ_MOVE, 16'h0000, 1'b1, 8'hFF);
		send_cmd(REQ_MOVE, 16'h0001, 1'b0, 8'h00);
		send_cmd(REQ_MOVE, 16'hFFFF, 1'b1, 8'hFF);
		send_cmd(REQ_RELEASE, 16'hFFFF, 1'b1, 8'hFF);
		send_cmd(REQ_ENABLE, 16'hFFFF, 1'b1, 8'hFF);
		repeat (SETUP_TICKS + HIGH_TICKS)
			send_cmd(REQ_TICK, 16'h0000, 1'b0, 8'h00);
		settle_move();

		run_setting(13'd4096, 10'd1000, 5'd16, 1'b1, 255, 6, 30, 30, 20, 1'b1);
		run_setting(13'd3000, 10'd1000, 5'd16, 1'b0, 15, 4, 0, 0, -1, 1'b1);
		run_setting(13'd1000, 10'd1000, 5'd4, 1'b1, 30, 1, 20, 50, -1, 1'b0);
		run_setting(13'd1, 10'd1, 5'd1, 1'b0, 0, 3, 50, 10, -1, 1'b1);
		run_setting(13'd200, 10'd60, 5'd0, 1'b1, 0, 3, 10, 40, -1, 1'b1);
		run_setting(13'd2500, 10'd800, 5'd8, 1'b1, 20, 3, 25, 25, -1, 1'b1);
		run_setting(13'd1200, 10'd500, 5'd2, 1'b0, 1, 2, 40, 0, -1, 1'b1);
		calm = 1'b1;
		run_setting(13'd4096, 10'd1000, 5'd31, 1'b0, 255, 8, 0, 0, -1, 1'b1);

		// A full-length move that runs past the end of the stimulus.
		send_cmd(REQ_MOVE, 16'hFFFF, 1'b1, 8'hFF);
		repeat (300)
			random_tick();
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Covered %0d command transactions under %0d register settings.", sent, settings);
		$display("Predicted %0d finished moves and %0d rejected commands.", moves_done, rejects);
		if (fails == 0 && pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
